@@ design/rvp_pkg.sv @@
// Shared opcodes, function codes, pipeline control types and sizing defaults.
package rvp_pkg;

    localparam int DATA_BYTES_DEF = 128;
    localparam int IMEM_WORDS_DEF = 64;
    localparam int RF_DEPTH       = 32;

    localparam logic [6:0] OPC_R  = 7'h33;
    localparam logic [6:0] OPC_I  = 7'h13;
    localparam logic [6:0] OPC_LW = 7'h03;
    localparam logic [6:0] OPC_SW = 7'h23;
    localparam logic [6:0] OPC_BR = 7'h63;

    localparam logic [6:0] F7_SUB = 7'h20;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_SLT = 3'd2;
    localparam logic [2:0] F3_BEQ = 3'd0;
    localparam logic [2:0] F3_BLT = 3'd4;

    typedef struct packed {
        logic       v;
        logic       br;
        logic       mw;
        logic       mr;
        logic       rw;
        logic [4:0] rd;
        logic [6:0] f7;
        logic [2:0] f3;
        logic [6:0] opc;
    } t_dx_ctl;

    typedef struct packed {
        logic       mw;
        logic       mr;
        logic       rw;
        logic [4:0] rd;
    } t_em_ctl;

    typedef struct packed {
        logic       ld;
        logic       rw;
        logic [4:0] rd;
    } t_mw_ctl;

    typedef struct packed {
        logic        wb_valid;
        logic [4:0]  wb_register;
        logic [31:0] wb_value;
        logic        store_valid;
        logic [6:0]  store_address;
        logic [31:0] store_value;
        logic        load_fault;
        logic        br_flush;
        logic        hazard_stall;
        logic [31:0] fetch_address;
    } t_result;

endpackage

@@ design/rv32_subset_five_stage_pipeline_unit.sv @@
// Top level of the five-stage RV32 subset pipeline with its stores and handshakes.
//
// Usage: each input word is either a clock tick (op = 0), which advances the
// pipeline once, or an instruction load (op = 1), which writes one word of
// the instruction store and leaves the pipeline untouched. Every input word
// yields exactly one result word: the writeback, store, load fault, branch and
// stall events of that tick plus the program counter after it.
// A word's result is registered at the edge that accepts it. Throughput is
// one word per cycle while no clearing pass runs and the receiver keeps up;
// the pipeline registers, the ALU, and the registered reads of the register
// file, instruction store and four data byte banks are all done in one pass,
// with the memories read at the addresses that the next state will need.
// The result sits in an output register; a new word is accepted while that
// is empty or taken in the same cycle, and when the receiver stalls, input stalls too.
// After reset a clearing pass zeroes the register file and both stores; no
// input word is accepted meanwhile, but start_address writes are taken.
module rv32_subset_five_stage_pipeline_unit
    import rvp_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF,
    parameter int IMEM_WORDS = IMEM_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_write_en,
    input  logic [31:0]        i_cfg_write_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic [5:0]         i_load_index,
    input  logic [31:0]        i_load_word,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_wb_valid,
    output logic [4:0]         o_wb_register,
    output logic signed [31:0] o_wb_value,
    output logic               o_store_valid,
    output logic [6:0]         o_store_address,
    output logic [31:0]        o_store_value,
    output logic               o_load_fault,
    output logic               o_br_flush,
    output logic               o_hazard_stall,
    output logic [31:0]        o_fetch_address
);

    localparam int DROWS = (DATA_BYTES + 3) / 4;
    localparam int DRW   = $clog2(DROWS);
    localparam int IW    = $clog2(IMEM_WORDS);
    localparam int CLR_A = (DROWS > RF_DEPTH) ? DROWS : RF_DEPTH;
    localparam int CLR_N = (IMEM_WORDS > CLR_A) ? IMEM_WORDS : CLR_A;
    localparam int CW    = $clog2(CLR_N + 1);

    // Architectural and pipeline state.
    logic [31:0] r_start, n_start;
    logic [31:0] r_pc, n_pc;
    logic [31:0] r_fd_w, n_fd_w;
    logic [31:0] r_fd_pc, n_fd_pc;
    logic [31:0] r_dx_a, n_dx_a;
    logic [31:0] r_dx_b, n_dx_b;
    logic [31:0] r_dx_imm, n_dx_imm;
    logic [31:0] r_dx_pc, n_dx_pc;
    t_dx_ctl     r_dx_ctl, n_dx_ctl;
    logic [31:0] r_em_alu, n_em_alu;
    logic [31:0] r_em_sd, n_em_sd;
    t_em_ctl     r_em_ctl, n_em_ctl;
    logic [31:0] r_mw_alu, n_mw_alu;
    logic [31:0] r_mw_ld, n_mw_ld;
    t_mw_ctl     r_mw_ctl, n_mw_ctl;

    logic [CW-1:0] r_clr;
    logic          clearing;
    logic          r_ov;
    t_result       r_out;
    t_result       res;

    logic accept, tick, load_item;

    // Decode and execute outputs.
    logic [4:0]  dec_rs1, dec_rs2;
    logic [31:0] dec_imm;
    t_dx_ctl     dec_ctl;
    logic [31:0] ex_alu;
    logic        ex_taken;

    // Memory read data, for the state the block is in now.
    logic [31:0] rs1_val, rs2_val, imem_rd;
    logic [7:0]  bank_rd [4];

    logic        wb_we;
    logic [31:0] wb_val;
    logic        mem_inb, st_en;
    logic [31:0] ld_data;
    logic        hazard;
    logic [31:0] fetch_off;
    logic        fetch_ok;
    logic [31:0] n_off;

    assign clearing  = (r_clr < CW'(CLR_N));
    assign o_ready   = !clearing && (!r_ov || i_ready);
    assign accept    = i_valid && o_ready;
    assign tick      = accept && !i_op;
    assign load_item = accept && i_op;

    rvp_decode u_decode (
        .i_word (r_fd_w),
        .o_rs1  (dec_rs1),
        .o_rs2  (dec_rs2),
        .o_imm  (dec_imm),
        .o_ctl  (dec_ctl)
    );

    rvp_execute u_execute (
        .i_ctl   (r_dx_ctl),
        .i_a     (r_dx_a),
        .i_b     (r_dx_b),
        .i_imm   (r_dx_imm),
        .o_alu   (ex_alu),
        .o_taken (ex_taken)
    );

    // Writeback and memory stage.
    assign wb_we   = r_mw_ctl.rw && (r_mw_ctl.rd != 5'd0);
    assign wb_val  = r_mw_ctl.ld ? r_mw_ld : r_mw_alu;
    assign mem_inb = (r_em_alu <= 32'(DATA_BYTES - 4));
    assign st_en   = r_em_ctl.mw && mem_inb;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ld_data[8*k +: 8] = bank_rd[r_em_alu[1:0] + 2'(k)];
        end
    end

    // A word in decode waits while any older instruction still writes one of its sources.
    always_comb begin
        hazard = 1'b0;
        if (r_dx_ctl.rw && (r_dx_ctl.rd != 5'd0) &&
            ((r_dx_ctl.rd == dec_rs1) || (r_dx_ctl.rd == dec_rs2))) begin
            hazard = 1'b1;
        end
        if (r_em_ctl.rw && (r_em_ctl.rd != 5'd0) &&
            ((r_em_ctl.rd == dec_rs1) || (r_em_ctl.rd == dec_rs2))) begin
            hazard = 1'b1;
        end
        if (r_mw_ctl.rw && (r_mw_ctl.rd != 5'd0) &&
            ((r_mw_ctl.rd == dec_rs1) || (r_mw_ctl.rd == dec_rs2))) begin
            hazard = 1'b1;
        end
    end

    assign fetch_off = r_pc - r_start;
    assign fetch_ok  = (fetch_off[1:0] == 2'd0) && (fetch_off[31:2] < 30'(IMEM_WORDS));

    // Next state of one tick; a config write or a load item touches only its own part.
    always_comb begin
        n_start  = r_start;
        n_pc     = r_pc;
        n_fd_w   = r_fd_w;
        n_fd_pc  = r_fd_pc;
        n_dx_a   = r_dx_a;
        n_dx_b   = r_dx_b;
        n_dx_imm = r_dx_imm;
        n_dx_pc  = r_dx_pc;
        n_dx_ctl = r_dx_ctl;
        n_em_alu = r_em_alu;
        n_em_sd  = r_em_sd;
        n_em_ctl = r_em_ctl;
        n_mw_alu = r_mw_alu;
        n_mw_ld  = r_mw_ld;
        n_mw_ctl = r_mw_ctl;
        res      = '0;

        if (i_cfg_write_en) begin
            n_start = i_cfg_write_data;
            n_pc    = i_cfg_write_data;
        end else if (tick) begin
            res.wb_valid    = wb_we;
            res.wb_register = wb_we ? r_mw_ctl.rd : 5'd0;
            res.wb_value    = wb_we ? wb_val : 32'd0;

            n_mw_alu    = r_em_alu;
            n_mw_ld     = (r_em_ctl.mr && mem_inb) ? ld_data : 32'd0;
            n_mw_ctl.rd = r_em_ctl.rd;
            n_mw_ctl.rw = r_em_ctl.rw;
            n_mw_ctl.ld = r_em_ctl.mr;
            res.load_fault    = r_em_ctl.mr && !mem_inb;
            res.store_valid   = st_en;
            res.store_address = st_en ? r_em_alu[6:0] : 7'd0;
            res.store_value   = st_en ? r_em_sd : 32'd0;

            n_em_alu = ex_alu;
            n_em_sd  = r_dx_b;
            n_em_ctl = '0;
            if (r_dx_ctl.v) begin
                n_em_ctl.rd = r_dx_ctl.rd;
                n_em_ctl.rw = r_dx_ctl.rw;
                n_em_ctl.mr = r_dx_ctl.mr;
                n_em_ctl.mw = r_dx_ctl.mw;
            end

            n_dx_a   = 32'd0;
            n_dx_b   = 32'd0;
            n_dx_imm = 32'd0;
            n_dx_pc  = 32'd0;
            n_dx_ctl = '0;

            if (ex_taken) begin
                // Branch taken: flush fetch/decode and decode/execute, redirect.
                res.br_flush = 1'b1;
                n_pc    = r_dx_pc + r_dx_imm;
                n_fd_w  = 32'd0;
                n_fd_pc = 32'd0;
            end else begin
                if ((r_fd_w != 32'd0) && hazard) begin
                    res.hazard_stall = 1'b1;
                end else begin
                    if (r_fd_w != 32'd0) begin
                        n_dx_a   = rs1_val;
                        n_dx_b   = rs2_val;
                        n_dx_imm = dec_imm;
                        n_dx_pc  = r_fd_pc;
                        n_dx_ctl = dec_ctl;
                    end
                    n_fd_pc = r_pc;
                    if (fetch_ok) begin
                        n_fd_w = imem_rd;
                        n_pc   = r_pc + 32'd4;
                    end else begin
                        n_fd_w = 32'd0;
                    end
                end
            end
        end
        res.fetch_address = n_pc;
    end

    // Register file: two copies give the two read ports; both take every write.
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;

    assign rf_we    = clearing ? (r_clr < CW'(RF_DEPTH)) : (tick && wb_we);
    assign rf_waddr = clearing ? r_clr[4:0] : r_mw_ctl.rd;
    assign rf_wdata = clearing ? 32'd0 : wb_val;

    rvp_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (n_fd_w[19:15]),
        .o_rdata (rs1_val)
    );

    rvp_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (n_fd_w[24:20]),
        .o_rdata (rs2_val)
    );

    // Instruction store, read at the word the next program counter points to.
    logic          im_we;
    logic [IW-1:0] im_waddr;
    logic [31:0]   im_wdata;

    assign n_off    = n_pc - n_start;
    assign im_we    = clearing ? (r_clr < CW'(IMEM_WORDS))
                               : (load_item && ({26'd0, i_load_index} < 32'(IMEM_WORDS)));
    assign im_waddr = clearing ? r_clr[IW-1:0] : IW'(i_load_index);
    assign im_wdata = clearing ? 32'd0 : i_load_word;

    rvp_ram #(.WIDTH(32), .DEPTH(IMEM_WORDS)) u_imem (
        .i_clk   (i_clk),
        .i_we    (im_we),
        .i_waddr (im_waddr),
        .i_wdata (im_wdata),
        .i_raddr (n_off[IW+1:2]),
        .o_rdata (imem_rd)
    );

    // Data store as four byte banks so an unaligned word touches each bank once.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [DRW-1:0] w_row, r_row;
        logic [1:0]     lane;
        logic           bk_we;
        logic [DRW-1:0] bk_waddr;
        logic [7:0]     bk_wdata;

        assign w_row    = r_em_alu[DRW+1:2] + DRW'(2'(b) < r_em_alu[1:0]);
        assign r_row    = n_em_alu[DRW+1:2] + DRW'(2'(b) < n_em_alu[1:0]);
        assign lane     = 2'(b) - r_em_alu[1:0];
        assign bk_we    = clearing ? (r_clr < CW'(DROWS)) : (tick && st_en);
        assign bk_waddr = clearing ? r_clr[DRW-1:0] : w_row;
        assign bk_wdata = clearing ? 8'd0 : r_em_sd[8*lane +: 8];

        rvp_ram #(.WIDTH(8), .DEPTH(DROWS)) u_bank (
            .i_clk   (i_clk),
            .i_we    (bk_we),
            .i_waddr (bk_waddr),
            .i_wdata (bk_wdata),
            .i_raddr (r_row),
            .o_rdata (bank_rd[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= 32'd0;
            r_pc     <= 32'd0;
            r_fd_w   <= 32'd0;
            r_fd_pc  <= 32'd0;
            r_dx_a   <= 32'd0;
            r_dx_b   <= 32'd0;
            r_dx_imm <= 32'd0;
            r_dx_pc  <= 32'd0;
            r_dx_ctl <= '0;
            r_em_alu <= 32'd0;
            r_em_sd  <= 32'd0;
            r_em_ctl <= '0;
            r_mw_alu <= 32'd0;
            r_mw_ld  <= 32'd0;
            r_mw_ctl <= '0;
            r_clr    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_start  <= n_start;
            r_pc     <= n_pc;
            r_fd_w   <= n_fd_w;
            r_fd_pc  <= n_fd_pc;
            r_dx_a   <= n_dx_a;
            r_dx_b   <= n_dx_b;
            r_dx_imm <= n_dx_imm;
            r_dx_pc  <= n_dx_pc;
            r_dx_ctl <= n_dx_ctl;
            r_em_alu <= n_em_alu;
            r_em_sd  <= n_em_sd;
            r_em_ctl <= n_em_ctl;
            r_mw_alu <= n_mw_alu;
            r_mw_ld  <= n_mw_ld;
            r_mw_ctl <= n_mw_ctl;
            if (clearing) begin
                r_clr <= r_clr + CW'(1);
            end
            if (accept) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_ov;
    assign o_wb_valid      = r_out.wb_valid;
    assign o_wb_register   = r_out.wb_register;
    assign o_wb_value      = $signed(r_out.wb_value);
    assign o_store_valid   = r_out.store_valid;
    assign o_store_address = r_out.store_address;
    assign o_store_value   = r_out.store_value;
    assign o_load_fault    = r_out.load_fault;
    assign o_br_flush      = r_out.br_flush;
    assign o_hazard_stall  = r_out.hazard_stall;
    assign o_fetch_address = r_out.fetch_address;

endmodule

@@ design/rvp_ram.sv @@
// Single-port-write, single-port-read memory with registered, write-first read data.
module rvp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/rvp_decode.sv @@
// Instruction decode: register numbers, immediate and execute control.
module rvp_decode
    import rvp_pkg::*;
(
    input  logic [31:0] i_word,
    output logic [4:0]  o_rs1,
    output logic [4:0]  o_rs2,
    output logic [31:0] o_imm,
    output t_dx_ctl     o_ctl
);

    logic [6:0] opc;

    assign opc   = i_word[6:0];
    assign o_rs1 = i_word[19:15];
    assign o_rs2 = i_word[24:20];

    always_comb begin
        case (opc)
            OPC_I, OPC_LW: o_imm = {{20{i_word[31]}}, i_word[31:20]};
            OPC_SW:        o_imm = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
            OPC_BR:        o_imm = {{19{i_word[31]}}, i_word[31], i_word[7],
                                    i_word[30:25], i_word[11:8], 1'b0};
            default:       o_imm = 32'd0;
        endcase
    end

    always_comb begin
        o_ctl     = '0;
        o_ctl.opc = opc;
        o_ctl.f3  = i_word[14:12];
        o_ctl.f7  = i_word[31:25];
        o_ctl.rd  = i_word[11:7];
        o_ctl.v   = 1'b1;
        o_ctl.rw  = (opc == OPC_R) || (opc == OPC_I) || (opc == OPC_LW);
        o_ctl.mr  = (opc == OPC_LW);
        o_ctl.mw  = (opc == OPC_SW);
        o_ctl.br  = (opc == OPC_BR);
    end

endmodule

@@ design/rvp_execute.sv @@
// Execute stage: ALU result and branch decision.
module rvp_execute
    import rvp_pkg::*;
(
    input  t_dx_ctl     i_ctl,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_imm,
    output logic [31:0] o_alu,
    output logic        o_taken
);

    logic [31:0] op2;
    logic        cond;
    logic        lt;

    assign op2 = ((i_ctl.opc == OPC_I) || (i_ctl.opc == OPC_LW) || (i_ctl.opc == OPC_SW))
                 ? i_imm : i_b;
    assign lt  = $signed(i_a) < $signed(op2);

    always_comb begin
        o_alu = 32'd0;
        cond  = 1'b0;
        if (i_ctl.v) begin
            case (i_ctl.opc)
                OPC_R: begin
                    case (i_ctl.f3)
                        F3_ADD:  o_alu = (i_ctl.f7 == F7_SUB) ? i_a - op2 : i_a + op2;
                        F3_SLL:  o_alu = i_a << op2[4:0];
                        F3_SLT:  o_alu = {31'd0, lt};
                        default: o_alu = 32'd0;
                    endcase
                end
                OPC_I: begin
                    case (i_ctl.f3)
                        F3_ADD:  o_alu = i_a + op2;
                        F3_SLL:  o_alu = i_a << op2[4:0];
                        default: o_alu = 32'd0;
                    endcase
                end
                OPC_LW, OPC_SW: o_alu = i_a + op2;
                OPC_BR: begin
                    case (i_ctl.f3)
                        F3_BEQ:  cond = (i_a == op2);
                        F3_BLT:  cond = lt;
                        default: cond = 1'b0;
                    endcase
                end
                default: o_alu = 32'd0;
            endcase
        end
    end

    assign o_taken = i_ctl.v && i_ctl.br && cond;

endmodule
